@@ hw/rtl/slfa_pkg.sv @@
package slfa_pkg;

  localparam int QUEUE_DEPTH   = 4;
  localparam int PAYLOAD_BYTES = 256;

  localparam int LANES     = 4;
  localparam int LEN_W     = 8;
  localparam int QD_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int WPOS_W    = $clog2(PAYLOAD_BYTES + 1);
  localparam int WPE       = (PAYLOAD_BYTES + 3) / 4;
  localparam int WORD_W    = (WPE > 1) ? $clog2(WPE) : 1;
  localparam int ADDR_W    = QD_W + WORD_W;
  localparam int FRAME_WORDS = 1 + WPE;
  localparam int SLOT_W    = $clog2(FRAME_WORDS);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(PAYLOAD_BYTES - 1);

  localparam int LEN_LSB   = 24;
  localparam int TXV_BIT   = 9;
  localparam int RXV_BIT   = 8;
  localparam logic [31:0] CTL_TXVALID = 32'h0000_0200;
  localparam logic [31:0] CTL_RXVALID = 32'h0000_0100;
  localparam logic [31:0] CTL_PARITY  = 32'h0000_0001;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SLOT  = 2'd2
  } slfa_action_t;

  // one access set for the four byte lanes of a store
  typedef struct packed {
    logic [LANES-1:0]      we;
    logic [ADDR_W-1:0]     waddr;
    logic [LANES-1:0][7:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } slfa_ram_cmd_t;

  // what the result stage needs to build one result word
  typedef struct packed {
    logic             is_slot;
    logic             sel_ctl;
    logic [31:0]      ctl_word;
    logic [LANES-1:0] tx_mask;
    logic             frame_end;
    logic             write_accepted;
    logic             read_valid;
    logic [1:0]       rd_lane;
  } slfa_res_info_t;

  function automatic logic [QD_W-1:0] ring_next(input logic [QD_W-1:0] p);
    logic [QD_W-1:0] r;
    r = (p == QD_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

endpackage

@@ hw/rtl/slfa_in_if.sv @@
interface slfa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  host_byte;
  logic        host_last;
  logic [31:0] spi_rx_word;

  modport source(output valid, output action, output host_byte, output host_last,
                 output spi_rx_word, input ready);
  modport sink(input valid, input action, input host_byte, input host_last,
               input spi_rx_word, output ready);
endinterface

@@ hw/rtl/slfa_out_if.sv @@
interface slfa_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] spi_tx_word;
  logic        frame_end;
  logic        write_accepted;
  logic [7:0]  read_byte;
  logic        read_valid;

  modport source(output valid, output spi_tx_word, output frame_end,
                 output write_accepted, output read_byte, output read_valid,
                 input ready);
  modport sink(input valid, input spi_tx_word, input frame_end,
               input write_accepted, input read_byte, input read_valid,
               output ready);
endinterface

@@ hw/rtl/slfa_byte_ram.sv @@
module slfa_byte_ram #(
  parameter int AW = 8,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/slfa_ctrl.sv @@
module slfa_ctrl import slfa_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  slfa_in_if.sink        in_chan,
  input  logic           s1_take,
  output logic           s1_valid,
  output slfa_res_info_t s1_info,
  output slfa_ram_cmd_t  tx_cmd,
  output slfa_ram_cmd_t  rx_cmd
);

  logic                  s1_valid_r, s1_valid_nxt;
  slfa_res_info_t        info_r, info_nxt;

  logic [QD_W-1:0]       tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [CNT_W-1:0]      tx_count_r, tx_count_nxt;
  logic                  tx_att_r, tx_att_nxt;
  logic [QD_W-1:0]       rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt;
  logic [CNT_W-1:0]      rx_count_r, rx_count_nxt;
  logic                  rx_att_r, rx_att_nxt;
  logic [31:0]           rx_control_r, rx_control_nxt;
  logic [31:0]           next_control_r, next_control_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [WPOS_W-1:0]     wpos_r, wpos_nxt;
  logic [LEN_W-1:0]      rpos_r, rpos_nxt;

  logic [LEN_W-1:0]      tx_len_r [QUEUE_DEPTH];
  logic [LEN_W-1:0]      rx_len_r [QUEUE_DEPTH];
  // bytes of a transmit entry ever written: writes always run up from byte zero
  logic [WPOS_W-1:0]     tx_fill_r [QUEUE_DEPTH];

  logic                  acc, in_ready;
  logic                  host_wr;
  logic                  tx_len_we, rx_len_we;
  logic [LEN_W-1:0]      tx_len_wdata, rx_len_wdata;

  logic [SLOT_W-1:0]     p, pw;
  logic                  last_slot;
  logic [SLOT_W+1:0]     byte_idx [LANES];
  logic [LANES-1:0]      lane_in_range, lane_filled;
  logic [WPOS_W-1:0]     fill_head, wpos_inc;
  logic [LEN_W-1:0]      rpos_c;

  // frame boundary results
  logic                  par_ok, acked, commit, tx_pop;
  logic [LEN_W-1:0]      rx_len_c;
  logic [QD_W-1:0]       b_rx_tail, b_tx_head;
  logic [CNT_W-1:0]      b_rx_count, b_tx_count;
  logic                  b_rx_att, b_tx_att;
  logic [31:0]           b_ctl;

  assign in_ready      = !s1_valid_r || s1_take;
  assign in_chan.ready = in_ready;
  assign acc           = in_chan.valid && in_ready;
  assign s1_valid      = s1_valid_r;
  assign s1_info       = info_r;

  assign p         = (slot_r >= SLOT_W'(FRAME_WORDS)) ? '0 : slot_r;
  assign pw        = p - 1'b1;
  assign last_slot = (p == SLOT_W'(FRAME_WORDS - 1));
  assign fill_head = tx_fill_r[tx_head_r];
  assign wpos_inc  = wpos_r + 1'b1;
  assign rpos_c    = (rpos_r > MAX_LEN) ? MAX_LEN : rpos_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      byte_idx[i]      = {pw, 2'(i)};
      lane_in_range[i] = 32'(byte_idx[i]) < 32'(PAYLOAD_BYTES);
      lane_filled[i]   = 32'(byte_idx[i]) < 32'(fill_head);
    end
  end

  always_comb begin
    par_ok   = ^rx_control_r;
    acked    = par_ok && rx_control_r[RXV_BIT];
    commit   = par_ok && rx_control_r[TXV_BIT] && rx_att_r;
    rx_len_c = (rx_control_r[LEN_LSB +: LEN_W] > MAX_LEN) ? MAX_LEN
                                                         : rx_control_r[LEN_LSB +: LEN_W];
    b_rx_tail  = commit ? ring_next(rx_tail_r) : rx_tail_r;
    b_rx_count = rx_count_r + CNT_W'(commit);
    b_rx_att   = commit ? 1'b0 : rx_att_r;
    if (!b_rx_att && b_rx_count < CNT_W'(QUEUE_DEPTH)) begin
      b_rx_att = 1'b1;
    end
    tx_pop     = tx_att_r && acked;
    b_tx_head  = tx_pop ? ring_next(tx_head_r) : tx_head_r;
    b_tx_count = (tx_pop && tx_count_r != '0) ? tx_count_r - 1'b1 : tx_count_r;
    b_tx_att   = tx_pop ? 1'b0 : tx_att_r;
    if (!b_tx_att && b_tx_count != '0) begin
      b_tx_att = 1'b1;
    end
    b_ctl = '0;
    if (b_tx_att) begin
      b_ctl = {tx_len_r[b_tx_head], 24'h0} | CTL_TXVALID;
    end
    if (b_rx_att) begin
      b_ctl = b_ctl | CTL_RXVALID;
    end
    if (!(^b_ctl)) begin
      b_ctl = b_ctl | CTL_PARITY;
    end
  end

  always_comb begin
    tx_cmd           = '0;
    rx_cmd           = '0;
    info_nxt         = '0;
    host_wr          = 1'b0;
    tx_len_we        = 1'b0;
    tx_len_wdata     = LEN_W'(wpos_r);
    rx_len_we        = 1'b0;
    rx_len_wdata     = rx_len_c;
    tx_head_nxt      = tx_head_r;
    tx_tail_nxt      = tx_tail_r;
    tx_count_nxt     = tx_count_r;
    tx_att_nxt       = tx_att_r;
    rx_head_nxt      = rx_head_r;
    rx_tail_nxt      = rx_tail_r;
    rx_count_nxt     = rx_count_r;
    rx_att_nxt       = rx_att_r;
    rx_control_nxt   = rx_control_r;
    next_control_nxt = next_control_r;
    slot_nxt         = slot_r;
    wpos_nxt         = wpos_r;
    rpos_nxt         = rpos_r;
    s1_valid_nxt     = s1_take ? 1'b0 : s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
      case (in_chan.action)
        ACT_WRITE: begin
          if (!(wpos_r == '0 && tx_count_r >= CNT_W'(QUEUE_DEPTH))) begin
            host_wr                  = 1'b1;
            tx_cmd.we[wpos_r[1:0]]   = 1'b1;
            tx_cmd.waddr             = {tx_tail_r, WORD_W'(wpos_r >> 2)};
            tx_cmd.wdata[wpos_r[1:0]] = in_chan.host_byte;
            info_nxt.write_accepted  = 1'b1;
            if (in_chan.host_last || wpos_inc >= WPOS_W'(PAYLOAD_BYTES)) begin
              tx_len_we    = 1'b1;
              tx_tail_nxt  = ring_next(tx_tail_r);
              tx_count_nxt = tx_count_r + 1'b1;
              wpos_nxt     = '0;
            end else begin
              wpos_nxt = wpos_inc;
            end
          end
        end
        ACT_READ: begin
          if (rx_count_r != '0) begin
            rx_cmd.re           = 1'b1;
            rx_cmd.raddr        = {rx_head_r, WORD_W'(rpos_c >> 2)};
            info_nxt.read_valid = 1'b1;
            info_nxt.rd_lane    = rpos_c[1:0];
            if (rpos_r >= rx_len_r[rx_head_r]) begin
              rx_head_nxt  = ring_next(rx_head_r);
              rx_count_nxt = rx_count_r - 1'b1;
              rpos_nxt     = '0;
            end else begin
              rpos_nxt = rpos_r + 1'b1;
            end
          end
        end
        ACT_SLOT: begin
          info_nxt.is_slot = 1'b1;
          if (p == '0) begin
            info_nxt.sel_ctl  = 1'b1;
            info_nxt.ctl_word = next_control_r;
            rx_control_nxt    = in_chan.spi_rx_word;
          end else begin
            tx_cmd.re        = 1'b1;
            tx_cmd.raddr     = {tx_head_r, WORD_W'(pw)};
            info_nxt.tx_mask = lane_in_range & lane_filled & {LANES{tx_att_r}};
            rx_cmd.we        = lane_in_range & {LANES{rx_att_r}};
            rx_cmd.waddr     = {rx_tail_r, WORD_W'(pw)};
            rx_cmd.wdata     = in_chan.spi_rx_word;
          end
          if (last_slot) begin
            info_nxt.frame_end = 1'b1;
            slot_nxt           = '0;
            rx_len_we          = commit;
            rx_tail_nxt        = b_rx_tail;
            rx_count_nxt       = b_rx_count;
            rx_att_nxt         = b_rx_att;
            tx_head_nxt        = b_tx_head;
            tx_count_nxt       = b_tx_count;
            tx_att_nxt         = b_tx_att;
            next_control_nxt   = b_ctl;
          end else begin
            slot_nxt = p + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      tx_head_r      <= '0;
      tx_tail_r      <= '0;
      tx_count_r     <= '0;
      tx_att_r       <= 1'b0;
      rx_head_r      <= '0;
      rx_tail_r      <= '0;
      rx_count_r     <= '0;
      rx_att_r       <= 1'b1;
      rx_control_r   <= '0;
      next_control_r <= CTL_RXVALID;
      slot_r         <= '0;
      wpos_r         <= '0;
      rpos_r         <= '0;
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
        tx_len_r[e]  <= '0;
        rx_len_r[e]  <= '0;
        tx_fill_r[e] <= '0;
      end
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      tx_head_r      <= tx_head_nxt;
      tx_tail_r      <= tx_tail_nxt;
      tx_count_r     <= tx_count_nxt;
      tx_att_r       <= tx_att_nxt;
      rx_head_r      <= rx_head_nxt;
      rx_tail_r      <= rx_tail_nxt;
      rx_count_r     <= rx_count_nxt;
      rx_att_r       <= rx_att_nxt;
      rx_control_r   <= rx_control_nxt;
      next_control_r <= next_control_nxt;
      slot_r         <= slot_nxt;
      wpos_r         <= wpos_nxt;
      rpos_r         <= rpos_nxt;
      if (tx_len_we) begin
        tx_len_r[tx_tail_r] <= tx_len_wdata;
      end
      if (rx_len_we) begin
        rx_len_r[rx_tail_r] <= rx_len_wdata;
      end
      for (int e = 0; e < QUEUE_DEPTH; e++) begin
        if (host_wr && tx_tail_r == QD_W'(e) && wpos_inc > tx_fill_r[e]) begin
          tx_fill_r[e] <= wpos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      info_r <= info_nxt;
    end
  end

  a_tx_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    tx_count_r <= CNT_W'(QUEUE_DEPTH)) else $error("tx ring count overflow");

  a_tx_att_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    tx_att_r |-> tx_count_r != '0) else $error("tx frame in flight with empty ring");

  a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_chan.action == ACT_SLOT && !last_slot) |=> slot_r == $past(p) + 1'b1)
    else $error("slot position did not advance");

  a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wpos_r < WPOS_W'(PAYLOAD_BYTES)) else $error("open chunk past payload size");

endmodule

@@ hw/rtl/slfa_result.sv @@
module slfa_result import slfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  slfa_res_info_t        s1_info,
  input  logic [LANES-1:0][7:0] tx_rdata,
  input  logic [LANES-1:0][7:0] rx_rdata,
  output logic                  s1_take,
  slfa_out_if.source            out_chan
);

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] spi_word_r, spi_word_nxt;
  logic        frame_end_r;
  logic        wr_acc_r;
  logic [7:0]  rd_byte_r, rd_byte_nxt;
  logic        rd_valid_r;
  logic [31:0] tx_word;

  assign s1_take = s1_valid && (!out_valid_r || out_chan.ready);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      tx_word[8*i +: 8] = s1_info.tx_mask[i] ? tx_rdata[i] : 8'h00;
    end
    if (!s1_info.is_slot) begin
      spi_word_nxt = '0;
    end else if (s1_info.sel_ctl) begin
      spi_word_nxt = s1_info.ctl_word;
    end else begin
      spi_word_nxt = tx_word;
    end
    rd_byte_nxt   = s1_info.read_valid ? rx_rdata[s1_info.rd_lane] : 8'h00;
    out_valid_nxt = s1_take ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      spi_word_r  <= spi_word_nxt;
      frame_end_r <= s1_info.frame_end;
      wr_acc_r    <= s1_info.write_accepted;
      rd_byte_r   <= rd_byte_nxt;
      rd_valid_r  <= s1_info.read_valid;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.spi_tx_word    = spi_word_r;
  assign out_chan.frame_end      = frame_end_r;
  assign out_chan.write_accepted = wr_acc_r;
  assign out_chan.read_byte      = rd_byte_r;
  assign out_chan.read_valid     = rd_valid_r;

endmodule

@@ hw/rtl/spi_frame_link_with_ack.sv @@
// master side of an spi frame link with acknowledgement
// in_chan takes one word per cycle unless stalled: a host byte write, a host byte
// read or one spi word slot (control word at frame start, then payload words)
// out_chan returns exactly one result word for every accepted input word
// an accepted word's result is registered in the byte-lane memory read stage,
// alongside its result information, and then in the output register before
// it is valid on out_chan
// throughput: one word per cycle unless out_chan stalls, set by the single read
// and single write port of each lane memory; every word uses at most one of each
// when out_chan stalls, one word waits in the output register and one in the
// memory read stage; in_chan.ready drops only once both are held
// reset clears the ring pointers, counts, lengths and link control state at
// once; the transmit and receive byte stores are not swept: per-entry fill
// marks make never-written transmit bytes go out as zero, and receive bytes are
// always written by a whole frame before the host can read them
module spi_frame_link_with_ack import slfa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  slfa_in_if.sink    in_chan,
  slfa_out_if.source out_chan
);

  logic                  s1_valid, s1_take;
  slfa_res_info_t        s1_info;
  slfa_ram_cmd_t         tx_cmd, rx_cmd;
  logic [LANES-1:0][7:0] tx_rdata, rx_rdata;

  slfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .tx_cmd   (tx_cmd),
    .rx_cmd   (rx_cmd)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    slfa_byte_ram #(.AW(ADDR_W), .DW(8)) u_tx_ram (
      .clk   (clk),
      .we    (tx_cmd.we[g]),
      .waddr (tx_cmd.waddr),
      .wdata (tx_cmd.wdata[g]),
      .re    (tx_cmd.re),
      .raddr (tx_cmd.raddr),
      .rdata (tx_rdata[g])
    );
    slfa_byte_ram #(.AW(ADDR_W), .DW(8)) u_rx_ram (
      .clk   (clk),
      .we    (rx_cmd.we[g]),
      .waddr (rx_cmd.waddr),
      .wdata (rx_cmd.wdata[g]),
      .re    (rx_cmd.re),
      .raddr (rx_cmd.raddr),
      .rdata (rx_rdata[g])
    );
  end

  slfa_result u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_info  (s1_info),
    .tx_rdata (tx_rdata),
    .rx_rdata (rx_rdata),
    .s1_take  (s1_take),
    .out_chan (out_chan)
  );

endmodule

@@ tb/spi_frame_link_with_ack_tb.sv @@
`timescale 1ns / 100ps

module spi_frame_link_with_ack_tb;
  import slfa_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 30;
  localparam int DRAIN_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  host_byte;
    logic        host_last;
    logic [31:0] spi_rx_word;
  } link_word_t;

  typedef struct packed {
    logic [31:0] spi_tx_word;
    logic        frame_end;
    logic        write_accepted;
    logic [7:0]  read_byte;
    logic        read_valid;
  } link_result_t;

  logic clk = 1'b0;
  logic rst_n;

  slfa_in_if  in_if();
  slfa_out_if out_if();

  spi_frame_link_with_ack dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #2 clk = ~clk;

  // link state as the block should hold it
  bit [7:0]    tx_bytes [QUEUE_DEPTH*PAYLOAD_BYTES];
  bit [7:0]    tx_len [QUEUE_DEPTH];
  int unsigned tx_rd = 0, tx_wr = 0, tx_cnt = 0;
  bit          tx_busy = 1'b0;
  bit [7:0]    rx_bytes [QUEUE_DEPTH*PAYLOAD_BYTES];
  bit [7:0]    rx_len [QUEUE_DEPTH];
  int unsigned rx_rd = 0, rx_wr = 0, rx_cnt = 0;
  bit          rx_busy = 1'b1;
  logic [31:0] partner_ctl = '0;
  logic [31:0] link_ctl = CTL_RXVALID;
  int unsigned slot_pos = 0, fill_pos = 0, drain_pos = 0;

  link_word_t   words_to_send[$];
  link_result_t results_due[$];
  int words_queued = 0;
  int words_taken  = 0;
  int gen_slot     = 0;
  int errors       = 0;
  int idle_cycles  = 0;
  int send_gap_pct = 0;
  int stall_pct    = 0;
  bit in_took      = 1'b0;

  function automatic link_result_t link_step(input link_word_t w);
    link_result_t r;
    int unsigned  p, idx, pos, len;
    logic [31:0]  word, ctl;
    bit           acked;
    r = '0;
    case (w.action)
      ACT_WRITE: begin
        // a new chunk is refused while the ring is full
        if (!(fill_pos == 0 && tx_cnt >= QUEUE_DEPTH)) begin
          tx_bytes[tx_wr*PAYLOAD_BYTES + fill_pos] = w.host_byte;
          fill_pos++;
          r.write_accepted = 1'b1;
          if (w.host_last || fill_pos >= PAYLOAD_BYTES) begin
            tx_len[tx_wr] = 8'(fill_pos - 1);
            tx_wr = (tx_wr + 1) % QUEUE_DEPTH;
            tx_cnt++;
            fill_pos = 0;
          end
        end
      end
      ACT_READ: begin
        if (rx_cnt > 0) begin
          pos = (drain_pos > PAYLOAD_BYTES - 1) ? PAYLOAD_BYTES - 1 : drain_pos;
          r.read_byte  = rx_bytes[rx_rd*PAYLOAD_BYTES + pos];
          r.read_valid = 1'b1;
          if (drain_pos >= rx_len[rx_rd]) begin
            rx_rd = (rx_rd + 1) % QUEUE_DEPTH;
            rx_cnt--;
            drain_pos = 0;
          end else begin
            drain_pos++;
          end
        end
      end
      ACT_SLOT: begin
        p = (slot_pos >= FRAME_WORDS) ? 0 : slot_pos;
        if (p == 0) begin
          r.spi_tx_word = link_ctl;
          partner_ctl   = w.spi_rx_word;
        end else begin
          word = '0;
          for (int i = 0; i < 4; i++) begin
            idx = 4*(p - 1) + i;
            if (idx < PAYLOAD_BYTES) begin
              if (tx_busy)
                word[8*i +: 8] = tx_bytes[tx_rd*PAYLOAD_BYTES + idx];
              if (rx_busy)
                rx_bytes[rx_wr*PAYLOAD_BYTES + idx] = w.spi_rx_word[8*i +: 8];
            end
          end
          r.spi_tx_word = word;
        end
        if (p + 1 >= FRAME_WORDS) begin
          r.frame_end = 1'b1;
          slot_pos = 0;
          // frame boundary: take the partner's ack and frame, then build next control
          acked = 1'b0;
          if (^partner_ctl) begin
            acked = partner_ctl[RXV_BIT];
            if (partner_ctl[TXV_BIT] && rx_busy) begin
              len = partner_ctl[LEN_LSB +: LEN_W];
              if (len > PAYLOAD_BYTES - 1)
                len = PAYLOAD_BYTES - 1;
              rx_len[rx_wr] = 8'(len);
              rx_wr = (rx_wr + 1) % QUEUE_DEPTH;
              rx_cnt++;
              rx_busy = 1'b0;
            end
          end
          if (!rx_busy && rx_cnt < QUEUE_DEPTH)
            rx_busy = 1'b1;
          if (tx_busy && acked) begin
            tx_rd = (tx_rd + 1) % QUEUE_DEPTH;
            if (tx_cnt > 0)
              tx_cnt--;
            tx_busy = 1'b0;
          end
          if (!tx_busy && tx_cnt > 0)
            tx_busy = 1'b1;
          ctl = '0;
          if (tx_busy)
            ctl = (32'(tx_len[tx_rd]) << LEN_LSB) | CTL_TXVALID;
          if (rx_busy)
            ctl |= CTL_RXVALID;
          if (!(^ctl))
            ctl |= CTL_PARITY;
          link_ctl = ctl;
        end else begin
          slot_pos = p + 1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // partner control word with odd parity, short lengths mostly
  function automatic logic [31:0] partner_control();
    logic [31:0] c;
    c = $urandom;
    c[LEN_LSB +: LEN_W] = ($urandom_range(0, 24) == 0) ? LEN_W'($urandom_range(0, 255))
                                                        : LEN_W'($urandom_range(0, 7));
    c[TXV_BIT] = ($urandom_range(0, 99) < 60);
    c[RXV_BIT] = ($urandom_range(0, 99) < 75);
    c[0] = 1'b0;
    c[0] = ~^c;
    return c;
  endfunction

  task automatic queue_word(input logic [1:0] act, input logic [7:0] b, input logic l,
                            input logic [31:0] rw);
    link_word_t w;
    w.action      = act;
    w.host_byte   = b;
    w.host_last   = l;
    w.spi_rx_word = rw;
    words_to_send.push_back(w);
    words_queued++;
    if (act == ACT_SLOT)
      gen_slot = (gen_slot + 1) % FRAME_WORDS;
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    link_word_t w;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (!in_if.valid || in_took) begin
        if (words_to_send.size() != 0 && !($urandom_range(0, 99) < send_gap_pct)) begin
          w = words_to_send.pop_front();
          in_if.valid       <= 1'b1;
          in_if.action      <= w.action;
          in_if.host_byte   <= w.host_byte;
          in_if.host_last   <= w.host_last;
          in_if.spi_rx_word <= w.spi_rx_word;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= !($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor, checker and watchdog on the rising edge
  always @(posedge clk) begin
    link_word_t   w;
    link_result_t want;
    bit           progress;
    progress = 1'b0;
    in_took  = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        progress = 1'b1;
        if (results_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result word: tx_word %08h", out_if.spi_tx_word);
        end else begin
          want = results_due.pop_front();
          if (out_if.spi_tx_word !== want.spi_tx_word ||
              out_if.frame_end !== want.frame_end ||
              out_if.write_accepted !== want.write_accepted ||
              out_if.read_byte !== want.read_byte ||
              out_if.read_valid !== want.read_valid) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: tx_word %08h/%08h end %0b/%0b wr_ok %0b/%0b",
                       want.spi_tx_word, out_if.spi_tx_word, want.frame_end,
                       out_if.frame_end, want.write_accepted, out_if.write_accepted,
                       " rd %02h/%02h rd_ok %0b/%0b (exp/got)",
                       want.read_byte, out_if.read_byte, want.read_valid,
                       out_if.read_valid);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        progress = 1'b1;
        in_took  = 1'b1;
        w.action      = in_if.action;
        w.host_byte   = in_if.host_byte;
        w.host_last   = in_if.host_last;
        w.spi_rx_word = in_if.spi_rx_word;
        results_due.push_back(link_step(w));
        words_taken++;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("spi_frame_link_with_ack_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase, mark, n;
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_WRITE;
    in_if.host_byte   = '0;
    in_if.host_last   = 1'b0;
    in_if.spi_rx_word = '0;
    out_if.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // one full chunk that closes by itself, then the ring filled to its limit
    for (int j = 0; j < PAYLOAD_BYTES; j++)
      queue_word(ACT_WRITE, 8'($urandom), 1'b0, $urandom);
    queue_word(ACT_READ, 8'h00, 1'b0, 32'h0000_0000);
    queue_word(ACT_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    queue_word(ACT_WRITE, 8'h00, 1'b1, 32'hFFFF_FFFF);
    queue_word(ACT_WRITE, 8'hFF, 1'b0, 32'h0000_0000);
    queue_word(ACT_WRITE, 8'h5A, 1'b1, 32'h0000_0000);
    queue_word(ACT_WRITE, 8'h81, 1'b1, 32'h0000_0000);
    // ring full now, host_last must be ignored
    queue_word(ACT_WRITE, 8'h33, 1'b1, 32'h0000_0000);
    // all-ones control word has even parity, so no ack
    queue_word(ACT_SLOT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    queue_word(ACT_SLOT, 8'h00, 1'b0, 32'h0000_0000);
    queue_word(ACT_SLOT, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    queue_word(ACT_READ, 8'hFF, 1'b1, 32'hFFFF_FFFF);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 54; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 54; end
        default: begin send_gap_pct = 27; stall_pct = 27; end
      endcase
      mark = words_queued;
      while (words_queued - mark < WORDS_PER_PHASE) begin
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++)
          queue_word(ACT_WRITE, 8'($urandom), (j == n - 1) && ($urandom_range(0, 7) != 0),
                     $urandom);
        if ($urandom_range(0, 99) < 85) begin
          // a run of slots with host traffic mixed in
          n = $urandom_range(FRAME_WORDS / 2, FRAME_WORDS);
          for (int j = 0; j < n; j++) begin
            if ($urandom_range(0, 9) == 0)
              queue_word($urandom_range(0, 1) ? ACT_READ : ACT_WRITE, 8'($urandom),
                         $urandom_range(0, 2) == 0, $urandom);
            queue_word(ACT_SLOT, 8'($urandom), 1'($urandom),
                       (gen_slot == 0 && $urandom_range(0, 9) != 0) ? partner_control()
                                                                     : $urandom);
          end
        end
        n = $urandom_range(0, 8);
        for (int j = 0; j < n; j++)
          queue_word(ACT_READ, 8'($urandom), 1'($urandom), $urandom);
        if ($urandom_range(0, 9) == 0)
          queue_word(2'($urandom), 8'($urandom), 1'($urandom), $urandom);
      end
      // sender holds off until every result of this phase is back
      while (words_taken != words_queued || results_due.size() != 0)
        @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && results_due.size() == 0)
      $display("spi_frame_link_with_ack_tb: PASS");
    else
      $display("spi_frame_link_with_ack_tb: FAIL");
    $finish;
  end

endmodule

@@ spi_frame_link_with_ack.f @@
hw/rtl/slfa_pkg.sv
hw/rtl/slfa_in_if.sv
hw/rtl/slfa_out_if.sv
hw/rtl/slfa_byte_ram.sv
hw/rtl/slfa_ctrl.sv
hw/rtl/slfa_result.sv
hw/rtl/spi_frame_link_with_ack.sv
tb/spi_frame_link_with_ack_tb.sv
